// ===== sv/lbmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbmm_pkg
// Shared widths, reset values, register indexes, controller states and the
// command/status bundles of the luma block-mean mosaic.
// ----------------------------------------------------------------------------
package lbmm_pkg;

  // fixed field widths
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int MEAN_W    = 8;
  localparam int COORD_W   = 9;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_BLOCK_SIZE = 8;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // controller states
  typedef enum logic [2:0] {
    ST_PREP1,
    ST_PREP2,
    ST_IDLE,
    ST_UPD,
    ST_DIV
  } lbmm_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } lbmm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } lbmm_stat_t;

endpackage

// ===== sv/lbmm_ram.sv =====
// ----------------------------------------------------------------------------
// lbmm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lbmm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lbmm_div.sv =====
// ----------------------------------------------------------------------------
// lbmm_div
// Restoring divider for the block mean, one quotient bit per cycle. The full
// quotient of the block sum is formed in SUM_W steps and its low MEAN_W bits
// are handed out as the mean.
// ----------------------------------------------------------------------------
module lbmm_div #(
  parameter int SUM_W  = 14,
  parameter int PROD_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           dividend,
  input  logic [PROD_W-1:0]          divisor,
  output logic                       done,
  output logic [lbmm_pkg::MEAN_W-1:0] quotient
);

  localparam int WIDE_W = PROD_W + SUM_W;
  localparam int CNT_W  = $clog2(SUM_W);

  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [WIDE_W-1:0] dsh_r, dsh_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              fits;

  // one compare and subtract per cycle
  always_comb begin
    fits     = (rem_r >= dsh_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = WIDE_W'(dividend);
      dsh_nxt  = WIDE_W'(divisor) << (SUM_W - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[SUM_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  // mean is the quotient truncated to its low bits
  assign done     = ~busy_r;
  assign quotient = q_r[lbmm_pkg::MEAN_W-1:0];

endmodule

// ===== sv/lbmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbmm_ctrl
// Sequencer of the mosaic: settles the size decode after reset and after a
// register write, then takes one pixel, updates the sums and, on a block's
// last pixel, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module lbmm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_valid,
  input  lbmm_pkg::lbmm_stat_t stat,
  output lbmm_pkg::lbmm_cmd_t  cmd
);

  lbmm_pkg::lbmm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbmm_pkg::ST_PREP1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lbmm_pkg::ST_PREP1: begin
        state_nxt = cfg_valid ? lbmm_pkg::ST_PREP1 : lbmm_pkg::ST_PREP2;
      end
      lbmm_pkg::ST_PREP2: begin
        state_nxt = cfg_valid ? lbmm_pkg::ST_PREP1 : lbmm_pkg::ST_IDLE;
      end
      lbmm_pkg::ST_IDLE: begin
        in_ready = ~cfg_valid;
        if (cfg_valid) begin
          state_nxt = lbmm_pkg::ST_PREP1;
        end else if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = lbmm_pkg::ST_UPD;
        end
      end
      lbmm_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        if (stat.emit) begin
          cmd.div_start = 1'b1;
          state_nxt     = lbmm_pkg::ST_DIV;
        end else begin
          state_nxt = lbmm_pkg::ST_IDLE;
        end
      end
      lbmm_pkg::ST_DIV: begin
        if (stat.div_done && stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = lbmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lbmm_dp.sv =====
// ----------------------------------------------------------------------------
// lbmm_dp
// Datapath of the mosaic: size registers and their block decode, position
// counters, per-column sum memory, running block sum, divider and output
// register.
// ----------------------------------------------------------------------------
module lbmm_dp #(
  parameter int MAX_WIDTH  = lbmm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lbmm_pkg::DEF_MAX_HEIGHT,
  parameter int BLOCK_SIZE = lbmm_pkg::DEF_BLOCK_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbmm_pkg::lbmm_cmd_t           cmd,
  output lbmm_pkg::lbmm_stat_t          stat,
  input  logic [lbmm_pkg::PIX_W-1:0]    in_pixel,
  input  logic                          in_frame_start,
  input  logic                          cfg_valid,
  input  logic [lbmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbmm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lbmm_pkg::COORD_W-1:0]  out_block_column,
  output logic [lbmm_pkg::COORD_W-1:0]  out_block_row,
  output logic [lbmm_pkg::MEAN_W-1:0]   out_mean_luma,
  output logic                          out_frame_last
);

  localparam int CFG_W     = lbmm_pkg::CFG_W;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int SUM_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BR_DEPTH  = (MAX_HEIGHT + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BC_W      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int BR_W      = (BR_DEPTH > 1) ? $clog2(BR_DEPTH) : 1;
  localparam int RX_W      = $clog2(BLOCK_SIZE);
  localparam int BSZ_W     = $clog2(BLOCK_SIZE + 1);
  localparam int PROD_W    = 2 * BSZ_W;
  localparam int SUM_W     = $clog2(BLOCK_SIZE * BLOCK_SIZE * ((1 << lbmm_pkg::PIX_W) - 1) + 1);
  localparam int WDM_W     = COL_W + BSZ_W;
  localparam int HDM_W     = ROW_W + BSZ_W;
  localparam int W_RECIP_I = (1 << COL_W) / BLOCK_SIZE;
  localparam int H_RECIP_I = (1 << ROW_W) / BLOCK_SIZE;

  localparam logic [COL_W-1:0] W_RECIP = COL_W'(W_RECIP_I);
  localparam logic [ROW_W-1:0] H_RECIP = ROW_W'(H_RECIP_I);
  localparam logic [RX_W-1:0]  RX_LAST = RX_W'(BLOCK_SIZE - 1);

  // size registers
  logic [CFG_W-1:0] fw_r, fh_r;

  // effective last column and row
  logic [CFG_W-1:0] fw_m1, fh_m1;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  // block decode of the last column and row
  logic [2*COL_W-1:0] wprod;
  logic [2*ROW_W-1:0] hprod;
  logic [COL_W-1:0]   wq0_r;
  logic [ROW_W-1:0]   hq0_r;
  logic [WDM_W-1:0]   wqb, wr0;
  logic [HDM_W-1:0]   hqb, hr0;
  logic [BC_W-1:0]    last_bc_r;
  logic [RX_W-1:0]    last_rx_r;
  logic [BR_W-1:0]    last_br_r;
  logic [RX_W-1:0]    last_ry_r;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic [RX_W-1:0]  rx_r, rx_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [BR_W-1:0]  br_r, br_nxt;
  logic [RX_W-1:0]  ry_r, ry_nxt;

  // clamped position of the arriving pixel
  logic [COL_W-1:0] scol;
  logic [BC_W-1:0]  sbc;
  logic [RX_W-1:0]  srx;
  logic [ROW_W-1:0] srow;
  logic [BR_W-1:0]  sbr;
  logic [RX_W-1:0]  sry;

  // captured pixel beat
  logic [lbmm_pkg::PIX_W-1:0] pix_r;
  logic [COL_W-1:0] ccol_r;
  logic [BC_W-1:0]  cbc_r;
  logic [RX_W-1:0]  crx_r;
  logic [ROW_W-1:0] crow_r;
  logic [BR_W-1:0]  cbr_r;
  logic [RX_W-1:0]  cry_r;

  // block sums
  logic [SUM_W-1:0] ram_rdata;
  logic [SUM_W-1:0] sum_r, sum_base, sum_nxt;
  logic             row_end, row_last, col_end, band_end;

  // divider and result
  logic [BSZ_W-1:0]  bw, bh;
  logic [PROD_W-1:0] divisor;
  logic              div_done;
  logic [lbmm_pkg::MEAN_W-1:0] div_q;
  logic [BC_W-1:0]   pend_bc_r;
  logic [BR_W-1:0]   pend_br_r;
  logic              pend_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [lbmm_pkg::COORD_W-1:0] out_bc_r, out_br_r;
  logic [lbmm_pkg::MEAN_W-1:0]  out_mean_r;
  logic              out_last_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= lbmm_pkg::RST_FRAME_WIDTH;
      fh_r <= lbmm_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbmm_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data;
        lbmm_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero size reads as one, oversize saturates
  always_comb begin
    fw_m1 = fw_r - CFG_W'(1);
    fh_m1 = fh_r - CFG_W'(1);
    if (fw_r == '0) begin
      wm1 = '0;
    end else if ({1'b0, fw_r} > (CFG_W + 1)'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = fw_m1[COL_W-1:0];
    end
    if (fh_r == '0) begin
      hm1 = '0;
    end else if ({1'b0, fh_r} > (CFG_W + 1)'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = fh_m1[ROW_W-1:0];
    end
  end

  // decode stage one: reciprocal estimate of the block index
  assign wprod = (2 * COL_W)'(wm1) * (2 * COL_W)'(W_RECIP);
  assign hprod = (2 * ROW_W)'(hm1) * (2 * ROW_W)'(H_RECIP);

  always_ff @(posedge clk) begin
    wq0_r <= wprod[2*COL_W-1:COL_W];
    hq0_r <= hprod[2*ROW_W-1:ROW_W];
  end

  // decode stage two: remainder and one-step correction
  assign wqb = WDM_W'(wq0_r) * WDM_W'(BLOCK_SIZE);
  assign hqb = HDM_W'(hq0_r) * HDM_W'(BLOCK_SIZE);
  assign wr0 = WDM_W'(wm1) - wqb;
  assign hr0 = HDM_W'(hm1) - hqb;

  always_ff @(posedge clk) begin
    if (wr0 >= WDM_W'(BLOCK_SIZE)) begin
      last_bc_r <= BC_W'(wq0_r + COL_W'(1));
      last_rx_r <= RX_W'(wr0 - WDM_W'(BLOCK_SIZE));
    end else begin
      last_bc_r <= BC_W'(wq0_r);
      last_rx_r <= RX_W'(wr0);
    end
    if (hr0 >= HDM_W'(BLOCK_SIZE)) begin
      last_br_r <= BR_W'(hq0_r + ROW_W'(1));
      last_ry_r <= RX_W'(hr0 - HDM_W'(BLOCK_SIZE));
    end else begin
      last_br_r <= BR_W'(hq0_r);
      last_ry_r <= RX_W'(hr0);
    end
  end

  // position of the arriving pixel, clamped to the frame
  always_comb begin
    if (in_frame_start) begin
      scol = '0;
      sbc  = '0;
      srx  = '0;
      srow = '0;
      sbr  = '0;
      sry  = '0;
    end else begin
      if (col_r > wm1) begin
        scol = wm1;
        sbc  = last_bc_r;
        srx  = last_rx_r;
      end else begin
        scol = col_r;
        sbc  = bc_r;
        srx  = rx_r;
      end
      if (row_r > hm1) begin
        srow = hm1;
        sbr  = last_br_r;
        sry  = last_ry_r;
      end else begin
        srow = row_r;
        sbr  = br_r;
        sry  = ry_r;
      end
    end
  end

  // capture the pixel beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r  <= in_pixel;
      ccol_r <= scol;
      cbc_r  <= sbc;
      crx_r  <= srx;
      crow_r <= srow;
      cbr_r  <= sbr;
      cry_r  <= sry;
    end
  end

  // per-column sums of the current band
  lbmm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.update & col_end),
    .waddr (cbc_r),
    .wdata (sum_nxt),
    .re    (cmd.capture),
    .raddr (sbc),
    .rdata (ram_rdata)
  );

  // running sum and block edges
  always_comb begin
    if (crx_r == '0) begin
      sum_base = (cry_r == '0) ? '0 : ram_rdata;
    end else begin
      sum_base = sum_r;
    end
    sum_nxt  = sum_base + SUM_W'(pix_r);
    row_end  = (ccol_r == wm1);
    row_last = (crow_r == hm1);
    col_end  = (crx_r == RX_LAST) || row_end;
    band_end = (cry_r == RX_LAST) || row_last;
  end

  // counter advance
  always_comb begin
    col_nxt = ccol_r + COL_W'(1);
    bc_nxt  = cbc_r;
    rx_nxt  = crx_r + RX_W'(1);
    row_nxt = crow_r;
    br_nxt  = cbr_r;
    ry_nxt  = cry_r;
    if (row_end) begin
      col_nxt = '0;
      bc_nxt  = '0;
      rx_nxt  = '0;
      if (row_last) begin
        row_nxt = '0;
        br_nxt  = '0;
        ry_nxt  = '0;
      end else begin
        row_nxt = crow_r + ROW_W'(1);
        if (cry_r == RX_LAST) begin
          ry_nxt = '0;
          br_nxt = cbr_r + BR_W'(1);
        end else begin
          ry_nxt = cry_r + RX_W'(1);
        end
      end
    end else if (crx_r == RX_LAST) begin
      rx_nxt = '0;
      bc_nxt = cbc_r + BC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      bc_r  <= '0;
      rx_r  <= '0;
      row_r <= '0;
      br_r  <= '0;
      ry_r  <= '0;
      sum_r <= '0;
    end else if (cmd.update) begin
      col_r <= col_nxt;
      bc_r  <= bc_nxt;
      rx_r  <= rx_nxt;
      row_r <= row_nxt;
      br_r  <= br_nxt;
      ry_r  <= ry_nxt;
      sum_r <= sum_nxt;
    end
  end

  // real block size at the right and bottom edges
  always_comb begin
    bw = (cbc_r == last_bc_r) ? (BSZ_W'(last_rx_r) + BSZ_W'(1)) : BSZ_W'(BLOCK_SIZE);
    bh = (cbr_r == last_br_r) ? (BSZ_W'(last_ry_r) + BSZ_W'(1)) : BSZ_W'(BLOCK_SIZE);
    divisor = PROD_W'(bw) * PROD_W'(bh);
  end

  lbmm_div #(
    .SUM_W  (SUM_W),
    .PROD_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_nxt),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // coordinates of the block being divided
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      pend_bc_r   <= cbc_r;
      pend_br_r   <= cbr_r;
      pend_last_r <= row_end & row_last;
    end
  end

  // output register
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bc_r   <= lbmm_pkg::COORD_W'(pend_bc_r);
      out_br_r   <= lbmm_pkg::COORD_W'(pend_br_r);
      out_mean_r <= div_q;
      out_last_r <= pend_last_r;
    end
  end

  // status to the controller
  assign stat.emit     = col_end & band_end;
  assign stat.div_done = div_done;
  assign stat.out_free = ~out_valid_r | out_ready;

  assign out_valid        = out_valid_r;
  assign out_block_column = out_bc_r;
  assign out_block_row    = out_br_r;
  assign out_mean_luma    = out_mean_r;
  assign out_frame_last   = out_last_r;

endmodule

// ===== sv/luma_block_mean_mosaic.sv =====
// ----------------------------------------------------------------------------
// luma_block_mean_mosaic
// Block-average pixelation of a luma plane in BLOCK_SIZE x BLOCK_SIZE tiles.
// ----------------------------------------------------------------------------
// Input beats carry one visible luma pixel in raster order; in_frame_start
// marks the top-left pixel of a frame, and the counters also wrap on their
// own after the last pixel. Output beats carry one finished block: its
// column and row index, the truncated mean of its real pixels and a flag
// for the frame's bottom-right block. Edge blocks are cut to the frame.
// The cfg channel writes frame_width (index 0) and frame_height (index 1);
// write it only while no pixel is in flight.
// Each pixel is captured with its sum memory read, then its sum is updated
// and written back. The last pixel of a block also runs the mean divider
// at one bit per cycle, and out_valid rises once the mean is loaded into
// the output register. After reset and after each cfg beat, the frame size
// is decoded into block terms in ST_PREP1 and ST_PREP2 with in_ready low.
// A finished block sits in the output register until taken; pixels keep
// flowing meanwhile, and only the next block end waits for the receiver.
// ----------------------------------------------------------------------------
module luma_block_mean_mosaic #(
  parameter int MAX_WIDTH  = lbmm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lbmm_pkg::DEF_MAX_HEIGHT,
  parameter int BLOCK_SIZE = lbmm_pkg::DEF_BLOCK_SIZE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lbmm_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lbmm_pkg::COORD_W-1:0]   out_block_column,
  output logic [lbmm_pkg::COORD_W-1:0]   out_block_row,
  output logic [lbmm_pkg::MEAN_W-1:0]    out_mean_luma,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbmm_pkg::CFG_W-1:0]     cfg_data
);

  lbmm_pkg::lbmm_cmd_t  cmd;
  lbmm_pkg::lbmm_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  lbmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  lbmm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_pixel         (in_pixel),
    .in_frame_start   (in_frame_start),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_mean_luma    (out_mean_luma),
    .out_frame_last   (out_frame_last)
  );

endmodule

// ===== test/tb_luma_block_mean_mosaic.sv =====
// ----------------------------------------------------------------------------
// tb_luma_block_mean_mosaic
// Self-checking bench for the 8x8 luma block-mean mosaic.
// ----------------------------------------------------------------------------
// Pixel beats come from a queue that the stimulus process fills phase by
// phase; frame sizes are reprogrammed only while the block is drained. A
// tile accumulator in the bench tracks the running block sums and predicts
// every block mean, which the output monitor compares field by field. The
// run covers reset sizes, zero and oversized sizes, counters left past a
// shrunken frame, 1x1 frames up to saturated 4096-wide and 4096-tall sizes,
// random gaps on both sides and one long output hold that backs up the
// pixel stream.
// ----------------------------------------------------------------------------
module tb_luma_block_mean_mosaic;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE        = lbmm_pkg::DEF_BLOCK_SIZE;
  localparam int MAXW        = lbmm_pkg::DEF_MAX_WIDTH;
  localparam int MAXH        = lbmm_pkg::DEF_MAX_HEIGHT;
  localparam int SUM_DEPTH   = (MAXW + TILE - 1) / TILE;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 24;
  localparam int GAP_PCT     = 26;
  localparam int EDGE_PIXELS = 48;

  typedef struct packed {
    logic [lbmm_pkg::PIX_W-1:0] luma;
    logic                       first;
  } pix_beat_t;

  typedef struct packed {
    logic [lbmm_pkg::COORD_W-1:0] col;
    logic [lbmm_pkg::COORD_W-1:0] row;
    logic [lbmm_pkg::MEAN_W-1:0]  mean;
    logic                         last;
  } tile_mean_t;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [lbmm_pkg::PIX_W-1:0]     in_pixel       = '0;
  logic                           in_frame_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [lbmm_pkg::COORD_W-1:0]   out_block_column;
  logic [lbmm_pkg::COORD_W-1:0]   out_block_row;
  logic [lbmm_pkg::MEAN_W-1:0]    out_mean_luma;
  logic                           out_frame_last;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [lbmm_pkg::CFG_IDX_W-1:0] cfg_index      = lbmm_pkg::REG_FRAME_WIDTH;
  logic [lbmm_pkg::CFG_W-1:0]     cfg_data       = '0;

  // bench control
  pix_beat_t   pix_pending[$];
  tile_mean_t  means_due[$];
  pix_beat_t   next_beat;
  tile_mean_t  want_mean;
  logic        steady    = 1'b0;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_total = 0;
  int unsigned pixels_taken   = 0;
  int unsigned blocks_checked = 0;
  int unsigned cfg_writes     = 0;

  // tile accumulator state
  int unsigned                tile_sums[SUM_DEPTH];
  bit                         tile_written[SUM_DEPTH];
  int unsigned                col_pos;
  int unsigned                row_pos;
  int unsigned                run_sum;
  logic [lbmm_pkg::CFG_W-1:0] frame_w_reg;
  logic [lbmm_pkg::CFG_W-1:0] frame_h_reg;

  luma_block_mean_mosaic uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_mean_luma    (out_mean_luma),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // zero reads as one, oversized saturates
  function automatic int unsigned eff_dim(logic [lbmm_pkg::CFG_W-1:0] v,
                                          int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void tile_clear();
    foreach (tile_sums[i]) begin
      tile_sums[i]    = 0;
      tile_written[i] = 1'b0;
    end
    col_pos     = 0;
    row_pos     = 0;
    run_sum     = 0;
    frame_w_reg = lbmm_pkg::RST_FRAME_WIDTH;
    frame_h_reg = lbmm_pkg::RST_FRAME_HEIGHT;
  endfunction

  // every tile column of the frame holds a parked sum
  function automatic bit tiles_primed(int unsigned w);
    for (int i = 0; i < (w + TILE - 1) / TILE; i++)
      if (!tile_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // add one pixel to its tile and queue the mean when the tile closes
  function automatic void tile_accumulate(logic [lbmm_pkg::PIX_W-1:0] luma, logic first);
    int unsigned w, h, col, row, bc, br, rx, ry, bw, bh;
    bit          row_end, col_end, band_end;
    tile_mean_t  res;
    w = eff_dim(frame_w_reg, MAXW);
    h = eff_dim(frame_h_reg, MAXH);
    if (first) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = (col_pos > w - 1) ? w - 1 : col_pos;
    row = (row_pos > h - 1) ? h - 1 : row_pos;
    bc = col / TILE;
    br = row / TILE;
    rx = col % TILE;
    ry = row % TILE;
    if (bc >= SUM_DEPTH) bc = SUM_DEPTH - 1;
    if (rx == 0) run_sum = ((ry == 0) ? 0 : tile_sums[bc]) + luma;
    else run_sum = run_sum + luma;
    row_end  = (col == w - 1);
    col_end  = (rx == TILE - 1) || row_end;
    band_end = (ry == TILE - 1) || (row == h - 1);
    if (col_end) begin
      tile_sums[bc]    = run_sum;
      tile_written[bc] = 1'b1;
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = (row >= h - 1) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    if (col_end && band_end) begin
      bw = w - bc * TILE;
      if (bw > TILE) bw = TILE;
      bh = h - br * TILE;
      if (bh > TILE) bh = TILE;
      res.col  = bc[lbmm_pkg::COORD_W-1:0];
      res.row  = br[lbmm_pkg::COORD_W-1:0];
      res.mean = lbmm_pkg::MEAN_W'(run_sum / (bw * bh));
      res.last = row_end && (row == h - 1);
      means_due.push_back(res);
    end
    pixels_taken++;
  endfunction

  function automatic void check_field(string tag, logic [lbmm_pkg::COORD_W-1:0] want,
                                      logic [lbmm_pkg::COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, tag, want, got);
      mismatch_total++;
    end
  endfunction

  // pixel driver: one beat per handshake, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) tile_accumulate(in_pixel, in_frame_start);
      if (!in_valid || in_ready) begin
        if (pix_pending.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
          next_beat = pix_pending.pop_front();
          in_valid       <= 1'b1;
          in_pixel       <= next_beat.luma;
          in_frame_start <= next_beat.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // block mean monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (means_due.size() == 0) begin
          $display("%0t: unexpected block col %0d row %0d mean %0d last %0d", $time,
                   out_block_column, out_block_row, out_mean_luma, out_frame_last);
          mismatch_total++;
        end else begin
          want_mean = means_due.pop_front();
          check_field("block_column", want_mean.col, out_block_column);
          check_field("block_row", want_mean.row, out_block_row);
          check_field("mean_luma", {1'b0, want_mean.mean}, {1'b0, out_mean_luma});
          check_field("frame_last", {8'd0, want_mean.last}, {8'd0, out_frame_last});
          blocks_checked++;
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  task automatic cfg_write(input logic [lbmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lbmm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lbmm_pkg::REG_FRAME_WIDTH) frame_w_reg = val;
    else frame_h_reg = val;
    cfg_writes++;
  endtask

  task automatic queue_beat(input logic [lbmm_pkg::PIX_W-1:0] luma, input logic first);
    pix_beat_t b;
    b.luma  = luma;
    b.first = first;
    pix_pending.push_back(b);
  endtask

  // random pixels, extremes now and then, optional stray frame starts
  task automatic queue_pixels(input int unsigned count, input bit open_frame,
                              input int unsigned noise_pct);
    logic [lbmm_pkg::PIX_W-1:0] luma;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) luma = $urandom_range(1) ? 8'hFF : 8'h00;
      else luma = lbmm_pkg::PIX_W'($urandom_range(255));
      queue_beat(luma, (k == 0 && open_frame) || ($urandom_range(99) < noise_pct));
    end
  endtask

  // sender pause: everything taken, every mean back, pipeline settled
  task automatic wait_drained();
    do @(posedge clk);
    while (pix_pending.size() != 0 || in_valid || means_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned pick, w, h, n, frames, noise, rand_beats, phase_idx;
    bit          open_frame;
    tile_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes, a few pixels that close no tile
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b0);
    queue_pixels(4, 1'b0, 0);
    wait_drained();

    // width shrinks under the column counter, single-row frame
    cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd3);
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd0);
    queue_pixels(4, 1'b0, 0);
    wait_drained();

    // zero sizes read as 1x1: every pixel is a block
    cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd0);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_pixels(1, 1'b0, 0);
    wait_drained();

    // 2x2 of full scale
    cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd2);
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd2);
    for (int i = 0; i < 4; i++) queue_beat(8'hFF, i == 0);
    wait_drained();

    // oversized height saturates, then shrinks under the row counter
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd8191);
    queue_pixels(6, 1'b1, 0);
    wait_drained();
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd2);
    queue_pixels(2, 1'b0, 0);
    wait_drained();

    // random phases of mostly whole frames
    rand_beats = 0;
    phase_idx  = 0;
    while (rand_beats < 360 || blocks_checked < 80 || phase_idx <= 5) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        cfg_write(lbmm_pkg::REG_FRAME_WIDTH, lbmm_pkg::CFG_W'($urandom_range(1, 12)));
        cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, lbmm_pkg::CFG_W'($urandom_range(1, 12)));
      end else if (pick < 63) begin
        cfg_write(lbmm_pkg::REG_FRAME_WIDTH, lbmm_pkg::CFG_W'($urandom_range(0, 20)));
      end else if (pick < 71) begin
        cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, lbmm_pkg::CFG_W'($urandom_range(0, 20)));
      end else if (pick < 84) begin
        cfg_write(lbmm_pkg::REG_FRAME_WIDTH,
                  lbmm_pkg::CFG_W'($urandom_range(1, eff_dim(frame_w_reg, MAXW))));
        cfg_write(lbmm_pkg::REG_FRAME_HEIGHT,
                  lbmm_pkg::CFG_W'($urandom_range(1, eff_dim(frame_h_reg, MAXH))));
      end else if (pick < 88) begin
        cfg_write(lbmm_pkg::REG_FRAME_WIDTH, lbmm_pkg::CFG_W'($urandom_range(100, 300)));
        cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, lbmm_pkg::CFG_W'($urandom_range(1, 9)));
      end
      w = eff_dim(frame_w_reg, MAXW);
      h = eff_dim(frame_h_reg, MAXH);
      // restart the frame where a tile column was never parked
      open_frame = !tiles_primed(w) || ($urandom_range(3) == 0);
      frames = $urandom_range(1, 3);
      n = frames * w * h;
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      if (n > 240) n = 240;
      noise = ($urandom_range(4) == 0) ? 3 : 0;
      if (phase_idx == 2) steady <= 1'b1;
      if (phase_idx == 5) begin
        // 1x1 frames under a long output hold fill the block up
        cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd1);
        cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd1);
        hold_go <= 1'b1;
        n = 60;
        noise = 10;
      end
      queue_pixels(n, open_frame, noise);
      rand_beats += n;
      wait_drained();
      steady <= 1'b0;
      phase_idx++;
    end

    // saturated width, one row: first tiles of the widest row
    cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd8191);
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd0);
    queue_pixels(EDGE_PIXELS, 1'b1, 0);
    wait_drained();

    // tallest frame, one column: first tile rows of the column
    cfg_write(lbmm_pkg::REG_FRAME_WIDTH, 13'd1);
    cfg_write(lbmm_pkg::REG_FRAME_HEIGHT, 13'd4096);
    queue_pixels(EDGE_PIXELS, 1'b1, 0);
    wait_drained();

    if (means_due.size() != 0) begin
      $display("%0t: %0d block means never arrived", $time, means_due.size());
      mismatch_total++;
    end
    $display("summary: %0d pixel beats, %0d block means compared, %0d register writes",
             pixels_taken, blocks_checked, cfg_writes);
    $display("summary: 1x1 to 4096-pixel frame sizes, counter clamps, %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatch_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("%0t: timeout with %0d pixels queued and %0d means due", $time,
             pix_pending.size(), means_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
